FILE: rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked out of reset only
`define FSBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define FSBC_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/fsbc_pkg.sv
package fsbc_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned NORMAL_FRAC_DEF = 14;
  localparam int unsigned POS_FRAC_DEF    = 8;

  localparam int unsigned NUM_PLANES  = 6;
  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned VEC_W       = 48;
  localparam int unsigned RADIUS_W    = 15;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;

  localparam logic OP_SPHERE = 1'b0;
  localparam logic OP_BOX    = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_PLANES-1:0][WORD_W-1:0] planes_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  // lane of w bits, lanes past bit 63 read as zero
  function automatic logic [31:0] lane_get(input logic [WORD_W-1:0] word,
                                           input int unsigned idx,
                                           input int unsigned w);
    logic [191:0] ext;
    logic [32:0]  m;
    ext = {128'd0, word} >> (idx * w);
    m = (33'd1 << w) - 33'd1;
    return ext[31:0] & m[31:0];
  endfunction

endpackage

FILE: rtl/frustum_sphere_box_cull.sv
// Frustum culling of spheres and model-transformed boxes against six planes
// held in configuration registers. Five-stage pipeline: one test enters per
// cycle unless the input is stalled; stall on the output side backs up
// through the stages, and empty stages still take new words. Configuration
// writes are registered and are meant for idle times.
`include "assert_macros.svh"

module frustum_sphere_box_cull import fsbc_pkg::*; #(
  parameter int unsigned COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = NORMAL_FRAC_DEF,
  parameter int unsigned POS_FRAC_BITS    = POS_FRAC_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic [VEC_W-1:0]     sphere_center_i,
  input  logic [RADIUS_W-1:0]  sphere_radius_i,
  input  logic [VEC_W-1:0]     box_min_i,
  input  logic [VEC_W-1:0]     box_max_i,
  input  logic [WORD_W-1:0]    model_row_x_i,
  input  logic [WORD_W-1:0]    model_row_y_i,
  input  logic [WORD_W-1:0]    model_row_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 visible_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  localparam int unsigned WW =
    (((2*COORD_WIDTH) > (COORD_WIDTH+POS_FRAC_BITS)) ?
     2*COORD_WIDTH : COORD_WIDTH+POS_FRAC_BITS) + 2;

  planes_t   plane_q;
  logic [4:0] v_q;
  logic [4:0] en;
  logic [2:0] op_q;
  stage_en_t stage_en;

  logic              op_s1_q;
  logic [VEC_W-1:0]  center_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [VEC_W-1:0]  bmin_q;
  logic [VEC_W-1:0]  bmax_q;
  word_t             row_x_q;
  word_t             row_y_q;
  word_t             row_z_q;

  logic signed [WW-1:0] world [NUM_CORNERS][3];
  logic box_vis;
  logic sph_vis;
  logic visible_d;
  logic visible_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PLANE_LEFT:   plane_q[0] <= cfg_data_i;
        REG_PLANE_RIGHT:  plane_q[1] <= cfg_data_i;
        REG_PLANE_BOTTOM: plane_q[2] <= cfg_data_i;
        REG_PLANE_TOP:    plane_q[3] <= cfg_data_i;
        REG_PLANE_NEAR:   plane_q[4] <= cfg_data_i;
        REG_PLANE_FAR:    plane_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage moves when it is empty or the next one moves
  assign en[4] = !v_q[4] || !out_stall_i;
  assign en[3] = !v_q[3] || en[4];
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign in_stall_o = !en[0];

  assign stage_en.s2 = en[1];
  assign stage_en.s3 = en[2];
  assign stage_en.s4 = en[3];
  assign stage_en.s5 = en[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < 5; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      op_s1_q  <= operation_i;
      center_q <= sphere_center_i;
      radius_q <= sphere_radius_i;
      bmin_q   <= box_min_i;
      bmax_q   <= box_max_i;
      row_x_q  <= model_row_x_i;
      row_y_q  <= model_row_y_i;
      row_z_q  <= model_row_z_i;
    end
    if (en[1]) op_q[0] <= op_s1_q;
    for (int s = 1; s < 3; s++) begin
      if (en[s+1]) op_q[s] <= op_q[s-1];
    end
    if (stage_en.s5) visible_q <= visible_d;
  end

  fsbc_xform #(
    .W  (COORD_WIDTH),
    .PF (POS_FRAC_BITS),
    .WW (WW)
  ) u_xform (
    .clk_i     (clk_i),
    .en_i      (stage_en),
    .box_min_i (bmin_q),
    .box_max_i (bmax_q),
    .row_x_i   (row_x_q),
    .row_y_i   (row_y_q),
    .row_z_i   (row_z_q),
    .world_o   (world)
  );

  fsbc_plane #(
    .W  (COORD_WIDTH),
    .NF (NORMAL_FRAC_BITS),
    .PF (POS_FRAC_BITS),
    .WW (WW)
  ) u_plane (
    .clk_i     (clk_i),
    .en_i      (stage_en),
    .planes_i  (plane_q),
    .world_i   (world),
    .visible_o (box_vis)
  );

  fsbc_sphere #(
    .W  (COORD_WIDTH),
    .NF (NORMAL_FRAC_BITS)
  ) u_sphere (
    .clk_i     (clk_i),
    .en_i      (stage_en),
    .planes_i  (plane_q),
    .center_i  (center_q),
    .radius_i  (radius_q),
    .visible_o (sph_vis)
  );

  always_comb begin
    case (op_q[2])
      OP_SPHERE: visible_d = sph_vis;
      OP_BOX:    visible_d = box_vis;
      default:   visible_d = sph_vis;
    endcase
  end

  assign out_valid_o = v_q[4];
  assign visible_o   = visible_q;

  `FSBC_ASSERT_ALL(a_stall_full, in_stall_o |-> (v_q == 5'h1f), "stall with empty stage")
  `FSBC_ASSERT(a_accept_fill, (in_valid_i && !in_stall_o) |=> v_q[0], "accepted word lost")
  `FSBC_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(visible_o)), "stalled result changed")

endmodule

FILE: rtl/fsbc_xform.sv
module fsbc_xform import fsbc_pkg::*; #(
  parameter int unsigned W  = COORD_WIDTH_DEF,
  parameter int unsigned PF = POS_FRAC_DEF,
  parameter int unsigned WW = (((2*W) > (W+PF)) ? 2*W : W+PF) + 2
) (
  input  logic                 clk_i,
  input  stage_en_t            en_i,
  input  logic [VEC_W-1:0]     box_min_i,
  input  logic [VEC_W-1:0]     box_max_i,
  input  word_t                row_x_i,
  input  word_t                row_y_i,
  input  word_t                row_z_i,
  output logic signed [WW-1:0] world_o [NUM_CORNERS][3]
);

  logic [31:0]          mn_raw [3];
  logic [31:0]          mx_raw [3];
  logic [31:0]          m_raw  [3][4];
  logic signed [W-1:0]  mn [3];
  logic signed [W-1:0]  mx [3];
  logic signed [W-1:0]  m  [3][4];
  word_t                rows [3];

  logic signed [2*W-1:0]  pmn_q [3][3];
  logic signed [2*W-1:0]  pmx_q [3][3];
  logic signed [W+PF-1:0] base_q [3];

  assign rows[0] = row_x_i;
  assign rows[1] = row_y_i;
  assign rows[2] = row_z_i;

  for (genvar j = 0; j < 3; j++) begin : g_pt
    assign mn_raw[j] = lane_get(WORD_W'(box_min_i), j, W);
    assign mx_raw[j] = lane_get(WORD_W'(box_max_i), j, W);
    assign mn[j] = mn_raw[j][W-1:0];
    assign mx[j] = mx_raw[j][W-1:0];
  end

  for (genvar k = 0; k < 3; k++) begin : g_row
    for (genvar j = 0; j < 4; j++) begin : g_col
      assign m_raw[k][j] = lane_get(rows[k], j, W);
      assign m[k][j] = m_raw[k][j][W-1:0];
    end
  end

  // corner products, min and max per axis
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pmn_q[k][j] <= mn[j] * m[k][j];
          pmx_q[k][j] <= mx[j] * m[k][j];
        end
        base_q[k] <= (W+PF)'(m[k][3]) <<< PF;
      end
    end
  end

  // world coordinates of the eight corners
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
        for (int k = 0; k < 3; k++) begin
          world_o[c][k] <= WW'(base_q[k])
            + (c[0] ? WW'(pmx_q[k][0]) : WW'(pmn_q[k][0]))
            + (c[1] ? WW'(pmx_q[k][1]) : WW'(pmn_q[k][1]))
            + (c[2] ? WW'(pmx_q[k][2]) : WW'(pmn_q[k][2]));
        end
      end
    end
  end

endmodule

FILE: rtl/fsbc_plane.sv
module fsbc_plane import fsbc_pkg::*; #(
  parameter int unsigned W  = COORD_WIDTH_DEF,
  parameter int unsigned NF = NORMAL_FRAC_DEF,
  parameter int unsigned PF = POS_FRAC_DEF,
  parameter int unsigned WW = (((2*W) > (W+PF)) ? 2*W : W+PF) + 2
) (
  input  logic                 clk_i,
  input  stage_en_t            en_i,
  input  planes_t              planes_i,
  input  logic signed [WW-1:0] world_i [NUM_CORNERS][3],
  output logic                 visible_o
);

  localparam int unsigned PW = W + WW;
  localparam int unsigned DW = ((PW > (W+NF+PF)) ? PW : W+NF+PF) + 2;

  logic [31:0]         n_raw [NUM_PLANES][4];
  logic signed [W-1:0] n     [NUM_PLANES][4];
  logic signed [PW-1:0] prod_q [NUM_PLANES][NUM_CORNERS][3];
  logic signed [DW-1:0] dsum  [NUM_PLANES][NUM_CORNERS];
  logic [NUM_PLANES-1:0] all_out;

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_pl
    for (genvar k = 0; k < 4; k++) begin : g_ln
      assign n_raw[p][k] = lane_get(planes_i[p], k, W);
      assign n[p][k] = n_raw[p][k][W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int c = 0; c < NUM_CORNERS; c++) begin
          for (int k = 0; k < 3; k++) begin
            prod_q[p][c][k] <= PW'(n[p][k]) * PW'(world_i[c][k]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      all_out[p] = 1'b1;
      for (int c = 0; c < NUM_CORNERS; c++) begin
        dsum[p][c] = (DW'(n[p][3]) <<< (NF + PF)) + DW'(prod_q[p][c][0])
                     + DW'(prod_q[p][c][1]) + DW'(prod_q[p][c][2]);
        all_out[p] = all_out[p] & dsum[p][c][DW-1];
      end
    end
  end

  assign visible_o = ~(|all_out);

endmodule

FILE: rtl/fsbc_sphere.sv
module fsbc_sphere import fsbc_pkg::*; #(
  parameter int unsigned W  = COORD_WIDTH_DEF,
  parameter int unsigned NF = NORMAL_FRAC_DEF
) (
  input  logic                clk_i,
  input  stage_en_t           en_i,
  input  planes_t             planes_i,
  input  logic [VEC_W-1:0]    center_i,
  input  logic [RADIUS_W-1:0] radius_i,
  output logic                visible_o
);

  localparam int unsigned SW0 = ((2*W) > (W+NF)) ? 2*W : W+NF;
  localparam int unsigned SW  = ((SW0 > (RADIUS_W+1+NF)) ? SW0 : RADIUS_W+1+NF) + 3;

  logic [31:0]           c_raw [3];
  logic signed [W-1:0]   c     [3];
  logic [31:0]           n_raw [NUM_PLANES][4];
  logic signed [W-1:0]   n     [NUM_PLANES][4];
  logic signed [2*W-1:0] prod_q [NUM_PLANES][3];
  logic [RADIUS_W-1:0]   rad_q;
  logic signed [SW-1:0]  dsum [NUM_PLANES];
  logic [NUM_PLANES-1:0] rej_q;

  for (genvar k = 0; k < 3; k++) begin : g_c
    assign c_raw[k] = lane_get(WORD_W'(center_i), k, W);
    assign c[k] = c_raw[k][W-1:0];
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_pl
    for (genvar k = 0; k < 4; k++) begin : g_ln
      assign n_raw[p][k] = lane_get(planes_i[p], k, W);
      assign n[p][k] = n_raw[p][k][W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[p][k] <= n[p][k] * c[k];
        end
      end
      rad_q <= radius_i;
    end
  end

  // distance plus radius, below zero means outside
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      dsum[p] = (SW'(n[p][3]) <<< NF) + SW'(prod_q[p][0]) + SW'(prod_q[p][1])
                + SW'(prod_q[p][2]) + (SW'($signed({1'b0, rad_q})) <<< NF);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        rej_q[p] <= dsum[p][SW-1];
      end
    end
    if (en_i.s4) begin
      visible_o <= ~(|rej_q);
    end
  end

endmodule
